// ===== rtl/core/tga_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_pkg
// Shared types and constants for the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
package tga_pkg;

  // pixel format codes as held in the format register
  typedef enum logic [1:0] {
    FMT_RAW    = 2'd0,
    FMT_RGB555 = 2'd1,
    FMT_BGR    = 2'd2,
    FMT_BGRA   = 2'd3
  } pix_fmt_t;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_BYTES_PER_PIXEL = 2'd0,
    REG_PIXEL_FORMAT    = 2'd1,
    REG_COMPRESSED      = 2'd2,
    REG_NONE            = 2'd3
  } reg_idx_t;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // reset values of the configuration registers
  localparam logic [2:0] BPP_RESET = 3'd3;
  localparam pix_fmt_t   FMT_RESET = FMT_BGR;
  localparam logic       CMP_RESET = 1'b1;

  // pixel size limits
  localparam logic [2:0] BPP_MIN = 3'd1;
  localparam logic [2:0] BPP_MAX = 3'd4;

  // run-length header values
  localparam logic [7:0] RUN_BIAS = 8'd127;

  // converted pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

endpackage

// ===== rtl/core/tga_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_in_if
// Byte stream channel into the decoder: valid, ready and one data byte.
// ----------------------------------------------------------------------------
interface tga_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       image_start;

  modport source (output valid, output data_byte, output image_start, input ready);
  modport sink   (input valid, input data_byte, input image_start, output ready);
endinterface

// ===== rtl/core/tga_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_out_if
// Pixel channel out of the decoder: valid, ready, RGBA and run length.
// ----------------------------------------------------------------------------
interface tga_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [7:0] run_length;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output run_length, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input run_length, output ready);
endinterface

// ===== rtl/core/tga_convert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_convert
// Turns the assembled pixel bytes into RGBA according to the pixel format.
// ----------------------------------------------------------------------------
module tga_convert (
  input  logic [31:0]       pixel,
  input  tga_pkg::pix_fmt_t fmt,
  output tga_pkg::rgba_t    rgba
);
  import tga_pkg::*;

  logic [7:0] b0, b1, b2, b3;

  assign b0 = pixel[7:0];
  assign b1 = pixel[15:8];
  assign b2 = pixel[23:16];
  assign b3 = pixel[31:24];

  // format select; 5-bit channels get their top bits copied below
  always_comb begin
    unique case (fmt)
      FMT_RAW: begin
        rgba = '{red: b0, green: b1, blue: b2, alpha: b3};
      end
      FMT_RGB555: begin
        rgba.red   = {b1[6:2], b1[6:4]};
        rgba.green = {b1[1:0], b0[7:5], b1[1:0], b0[7]};
        rgba.blue  = {b0[4:0], b0[4:2]};
        rgba.alpha = 8'd0;
      end
      FMT_BGR: begin
        rgba = '{red: b2, green: b1, blue: b0, alpha: 8'd0};
      end
      FMT_BGRA: begin
        rgba = '{red: b2, green: b1, blue: b0, alpha: b3};
      end
    endcase
  end

endmodule

// ===== rtl/core/tga_rle_pixel_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Decodes TGA image data, one byte per transfer, into RGBA pixels with runs.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle: the packet and pixel state update
// in a single pass, and the converted pixel is held in an output register, so a
// new byte is taken whenever that register is empty or is being drained in the
// same cycle. A pixel comes out in the cycle after its last byte is taken.
// Packet headers and the leading bytes of a pixel give no output. Set
// image_start on the first byte of each image to clear the packet state.
// Program pixel size, format and compression only while the stream is idle.
module tga_rle_pixel_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  tga_in_if.sink                           in_chan,
  tga_out_if.source                        out_chan,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tga_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [tga_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [tga_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import tga_pkg::*;

  // configuration registers
  logic [2:0] bpp_r;
  pix_fmt_t   fmt_r;
  logic       cmp_r;

  // packet state
  logic        awaiting_header_r, awaiting_header_nxt;
  logic        in_repeat_r,       in_repeat_nxt;
  logic [7:0]  pixels_left_r,     pixels_left_nxt;
  logic [1:0]  byte_pos_r,        byte_pos_nxt;
  logic [31:0] pixel_bytes_r,     pixel_bytes_nxt;

  // output register
  logic        out_valid_r;
  rgba_t       rgba_r;
  logic [7:0]  run_r;

  logic        in_xfer;
  logic        emit;
  logic [7:0]  run_nxt;
  logic [31:0] pix_done;
  logic [2:0]  size;
  logic [1:0]  pos_inc;
  logic [31:0] pix_merged;
  rgba_t       rgba_nxt;
  reg_idx_t    reg_idx;

  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign pready  = 1'b1;

  // apb write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r <= BPP_RESET;
      fmt_r <= FMT_RESET;
      cmp_r <= CMP_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_BYTES_PER_PIXEL: bpp_r <= pwdata[2:0];
        REG_PIXEL_FORMAT:    fmt_r <= pix_fmt_t'(pwdata[1:0]);
        REG_COMPRESSED:      cmp_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // apb read
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_BYTES_PER_PIXEL: prdata[2:0] = bpp_r;
      REG_PIXEL_FORMAT:    prdata[1:0] = fmt_r;
      REG_COMPRESSED:      prdata[0]   = cmp_r;
      default: ;
    endcase
  end

  // pixel size clamped to the legal range
  always_comb begin
    if (bpp_r < BPP_MIN) size = BPP_MIN;
    else if (bpp_r > BPP_MAX) size = BPP_MAX;
    else size = bpp_r;
  end

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  // byte handling: header, pixel byte, pixel end
  always_comb begin
    awaiting_header_nxt = awaiting_header_r;
    in_repeat_nxt       = in_repeat_r;
    pixels_left_nxt     = pixels_left_r;
    byte_pos_nxt        = byte_pos_r;
    pixel_bytes_nxt     = pixel_bytes_r;
    emit                = 1'b0;
    run_nxt             = 8'd1;
    pix_done            = '0;
    pix_merged          = '0;
    pos_inc             = '0;

    if (in_chan.image_start) begin
      awaiting_header_nxt = 1'b1;
      in_repeat_nxt       = 1'b0;
      pixels_left_nxt     = '0;
      byte_pos_nxt        = '0;
      pixel_bytes_nxt     = '0;
    end

    if (cmp_r && awaiting_header_nxt) begin
      // header byte opens a repeat or a raw packet
      in_repeat_nxt       = in_chan.data_byte[7];
      pixels_left_nxt     = in_chan.data_byte[7] ? (in_chan.data_byte - RUN_BIAS)
                                                 : (in_chan.data_byte + 8'd1);
      awaiting_header_nxt = 1'b0;
      byte_pos_nxt        = '0;
      pixel_bytes_nxt     = '0;
    end else begin
      pix_merged = pixel_bytes_nxt | ({24'd0, in_chan.data_byte} << {byte_pos_nxt, 3'b000});
      pos_inc    = byte_pos_nxt + 2'd1;
      if (pos_inc != 2'd0 && {1'b0, pos_inc} < size) begin
        byte_pos_nxt    = pos_inc;
        pixel_bytes_nxt = pix_merged;
      end else begin
        emit     = 1'b1;
        pix_done = pix_merged;
        if (cmp_r) begin
          if (in_repeat_nxt) begin
            run_nxt         = pixels_left_nxt;
            pixels_left_nxt = '0;
          end else if (pixels_left_nxt != 8'd0) begin
            pixels_left_nxt = pixels_left_nxt - 8'd1;
          end
          if (pixels_left_nxt == 8'd0) begin
            awaiting_header_nxt = 1'b1;
            in_repeat_nxt       = 1'b0;
          end
          if (run_nxt == 8'd0) run_nxt = 8'd1;
        end
        byte_pos_nxt    = '0;
        pixel_bytes_nxt = '0;
      end
    end
  end

  tga_convert u_convert (
    .pixel (pix_done),
    .fmt   (fmt_r),
    .rgba  (rgba_nxt)
  );

  // packet state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_header_r <= 1'b1;
      in_repeat_r       <= 1'b0;
      pixels_left_r     <= '0;
      byte_pos_r        <= '0;
      pixel_bytes_r     <= '0;
    end else if (in_xfer) begin
      awaiting_header_r <= awaiting_header_nxt;
      in_repeat_r       <= in_repeat_nxt;
      pixels_left_r     <= pixels_left_nxt;
      byte_pos_r        <= byte_pos_nxt;
      pixel_bytes_r     <= pixel_bytes_nxt;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      rgba_r <= rgba_nxt;
      run_r  <= run_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.red        = rgba_r.red;
  assign out_chan.green      = rgba_r.green;
  assign out_chan.blue       = rgba_r.blue;
  assign out_chan.alpha      = rgba_r.alpha;
  assign out_chan.run_length = run_r;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Bench for the TGA run-length pixel decoder. Feeds byte streams of packets and
// raw pixels under many size, format and mode settings, predicts each pixel in
// a scoreboard and compares every output transfer field by field.
// ----------------------------------------------------------------------------
module tb;
  import tga_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int PHASE_BYTES    = 125;
  localparam int NUM_PHASES     = 16;

  // register settings per phase, extremes and out-of-range sizes included
  localparam logic [2:0] PH_BPP [NUM_PHASES] = '{
    3'd3, 3'd1, 3'd2, 3'd4, 3'd0, 3'd7, 3'd5, 3'd6,
    3'd3, 3'd4, 3'd2, 3'd1, 3'd4, 3'd3, 3'd2, 3'd1
  };
  localparam pix_fmt_t PH_FMT [NUM_PHASES] = '{
    FMT_BGR, FMT_RAW, FMT_RGB555, FMT_BGRA, FMT_RAW, FMT_BGRA, FMT_RGB555, FMT_BGR,
    FMT_BGRA, FMT_RAW, FMT_RGB555, FMT_BGR, FMT_BGRA, FMT_BGR, FMT_RGB555, FMT_RAW
  };
  localparam logic PH_CMP [NUM_PHASES] = '{
    1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1
  };

  typedef struct {
    rgba_t      px;
    logic [7:0] run;
  } pixel_exp_t;

  typedef struct {
    logic [7:0] data;
    logic       start;
  } stream_byte_t;

  // pixel predictor and store of expected pixels
  class decoder_scoreboard;
    logic [2:0]   bpp_reg;
    pix_fmt_t     fmt_reg;
    logic         cmp_reg;
    logic         hdr_wait;
    logic         rep_pkt;
    logic [7:0]   px_left;
    logic [1:0]   byte_pos;
    logic [31:0]  px_bytes;
    pixel_exp_t   exp_q[$];
    int           errors;
    int           pixels_checked;
    int           bytes_taken;

    function new();
      bpp_reg = BPP_RESET;
      fmt_reg = FMT_RESET;
      cmp_reg = CMP_RESET;
      errors = 0;
      pixels_checked = 0;
      bytes_taken = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      hdr_wait = 1'b1;
      rep_pkt  = 1'b0;
      px_left  = 8'd0;
      byte_pos = 2'd0;
      px_bytes = 32'd0;
    endfunction

    function void set_register(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_BYTES_PER_PIXEL: bpp_reg = value[2:0];
        REG_PIXEL_FORMAT:    fmt_reg = pix_fmt_t'(value[1:0]);
        REG_COMPRESSED:      cmp_reg = value[0];
        default: ;
      endcase
    endfunction

    // 5-bit channel in the top bits, widened by replicating its top bits
    function int unsigned expand5(int unsigned v);
      int unsigned m;
      m = v & 32'hf8;
      return (m + (m >> 5)) & 32'hff;
    endfunction

    // advance the packet state by one accepted byte
    function void note_byte(logic [7:0] data, logic start);
      int unsigned size;
      int unsigned w0, w1;
      logic [7:0]  run;
      pixel_exp_t  e;
      bytes_taken++;
      size = bpp_reg;
      if (size < 1) size = 1;
      if (size > 4) size = 4;
      if (start) clear_packet();

      // packet header
      if (cmp_reg && hdr_wait) begin
        if (data >= 8'd128) begin
          rep_pkt = 1'b1;
          px_left = data - RUN_BIAS;
        end else begin
          rep_pkt = 1'b0;
          px_left = data + 8'd1;
        end
        hdr_wait = 1'b0;
        byte_pos = 2'd0;
        px_bytes = 32'd0;
        return;
      end

      // collect pixel bytes
      px_bytes = px_bytes | (32'(data) << (8 * byte_pos));
      byte_pos = byte_pos + 2'd1;
      if (byte_pos != 2'd0 && byte_pos < size) return;

      // run length and packet bookkeeping
      run = 8'd1;
      if (cmp_reg) begin
        if (rep_pkt) begin
          run = px_left;
          px_left = 8'd0;
        end else if (px_left > 8'd0) begin
          px_left = px_left - 8'd1;
        end
        if (px_left == 8'd0) begin
          hdr_wait = 1'b1;
          rep_pkt = 1'b0;
        end
        if (run < 8'd1) run = 8'd1;
      end

      // format conversion
      w0 = px_bytes[7:0];
      w1 = px_bytes[15:8];
      case (fmt_reg)
        FMT_RAW: begin
          e.px.red   = px_bytes[7:0];
          e.px.green = px_bytes[15:8];
          e.px.blue  = px_bytes[23:16];
          e.px.alpha = px_bytes[31:24];
        end
        FMT_RGB555: begin
          e.px.red   = 8'(expand5(w1 << 1));
          e.px.green = 8'(expand5(((w0 & 32'he0) >> 2) + ((w1 & 32'h03) << 6)));
          e.px.blue  = 8'(expand5(w0 << 3));
          e.px.alpha = 8'd0;
        end
        FMT_BGR: begin
          e.px.red   = px_bytes[23:16];
          e.px.green = px_bytes[15:8];
          e.px.blue  = px_bytes[7:0];
          e.px.alpha = 8'd0;
        end
        default: begin
          e.px.red   = px_bytes[23:16];
          e.px.green = px_bytes[15:8];
          e.px.blue  = px_bytes[7:0];
          e.px.alpha = px_bytes[31:24];
        end
      endcase
      e.run = run;
      exp_q.push_back(e);
      px_bytes = 32'd0;
      byte_pos = 2'd0;
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      end
    endfunction

    // compare one output transfer with the oldest expected pixel
    function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic [7:0] a, logic [7:0] run);
      pixel_exp_t e;
      if (exp_q.size() == 0) begin
        errors++;
        $display("%0t: pixel with none expected, actual r=0x%0h g=0x%0h b=0x%0h a=0x%0h run=%0d",
                 $time, r, g, b, a, run);
        return;
      end
      e = exp_q.pop_front();
      compare_field("red", e.px.red, r);
      compare_field("green", e.px.green, g);
      compare_field("blue", e.px.blue, b);
      compare_field("alpha", e.px.alpha, a);
      compare_field("run_length", e.run, run);
      pixels_checked++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  tga_in_if  in_bus ();
  tga_out_if out_bus ();

  decoder_scoreboard sb;
  stream_byte_t      stream_q[$];
  int                send_idle_pct;
  int                recv_stall_pct;
  int                idle_cycles;
  int                phases_run;

  tga_rle_pixel_decoder i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  // receiver back-pressure
  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // transfer monitor, checking and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        sb.check_pixel(out_bus.red, out_bus.green, out_bus.blue, out_bus.alpha,
                       out_bus.run_length);
      end
      if (in_bus.valid && in_bus.ready) begin
        sb.note_byte(in_bus.data_byte, in_bus.image_start);
      end
      if ((out_bus.valid && out_bus.ready) || (in_bus.valid && in_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic push_byte(logic [7:0] data, logic start);
    stream_byte_t s;
    s.data = data;
    s.start = start;
    stream_q.push_back(s);
  endtask

  task automatic push_pixel(int size, logic start);
    for (int i = 0; i < size; i++) begin
      push_byte(8'($urandom), (i == 0) ? start : 1'b0);
    end
  endtask

  // packet stream for one phase: mostly well-formed, some stray bytes
  task automatic build_phase_stream(int target, logic [2:0] bpp, logic cmp);
    int   size;
    int   hdr;
    logic first;
    size = bpp;
    if (size < 1) size = 1;
    if (size > 4) size = 4;
    stream_q.delete();
    first = ($urandom_range(3) != 0);
    while (stream_q.size() < target) begin
      if ($urandom_range(9) == 0) begin
        push_byte(8'($urandom), ($urandom_range(15) == 0));
      end else if (cmp) begin
        if ($urandom_range(1) == 1) begin
          hdr = 128 + (($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(15));
          push_byte(8'(hdr), first || ($urandom_range(15) == 0));
          push_pixel(size, 1'b0);
        end else begin
          hdr = ($urandom_range(19) == 0) ? $urandom_range(127) : $urandom_range(7);
          push_byte(8'(hdr), first || ($urandom_range(15) == 0));
          repeat (hdr + 1) push_pixel(size, 1'b0);
        end
      end else begin
        push_pixel(size, first || ($urandom_range(15) == 0));
      end
      first = 1'b0;
    end
    // leave a pixel or packet half done for the next setting
    if ($urandom_range(1) == 1) begin
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
    end
  endtask

  // drive the queued bytes; valid holds until the transfer happens
  task automatic send_bytes();
    int   idx;
    logic held;
    idx = 0;
    held = 1'b0;
    while (idx < stream_q.size()) begin
      @(negedge clk);
      if (!held && ($urandom_range(99) < send_idle_pct)) begin
        in_bus.valid       <= 1'b0;
        in_bus.data_byte   <= 8'($urandom);
        in_bus.image_start <= 1'($urandom);
      end else begin
        in_bus.valid       <= 1'b1;
        in_bus.data_byte   <= stream_q[idx].data;
        in_bus.image_start <= stream_q[idx].start;
        held = 1'b1;
      end
      @(posedge clk);
      if (in_bus.valid && in_bus.ready) begin
        idx++;
        held = 1'b0;
      end
    end
    @(negedge clk);
    in_bus.valid <= 1'b0;
  endtask

  task automatic drain_pixels();
    while (sb.exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // apb write then read back
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    logic [CFG_ADDR_W-1:0] addr;
    addr = {idx, 2'b00};
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_register(idx, value);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.compare_field("register readback", value, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
      3: begin send_idle_pct = 23; recv_stall_pct = 23; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  initial begin
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.data_byte = 8'd0;
    in_bus.image_start = 1'b0;
    out_bus.ready = 1'b0;
    idle_cycles = 0;
    phases_run = 0;
    set_idling(0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, run extremes, raw packet, start mid-pixel
    stream_q.delete();
    push_byte(8'h80, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b0);
    push_byte(8'ha5, 1'b0);
    push_byte(8'h5a, 1'b0);
    push_byte(8'hc3, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b0);
    push_byte(8'h82, 1'b1);
    push_byte(8'h9a, 1'b0);
    push_byte(8'hbc, 1'b0);
    push_byte(8'hde, 1'b0);
    send_bytes();

    // random phases over register settings and idling patterns
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_idling(0);
      drain_pixels();
      write_reg(REG_BYTES_PER_PIXEL, 32'(PH_BPP[ph]));
      write_reg(REG_PIXEL_FORMAT, 32'(PH_FMT[ph]));
      write_reg(REG_COMPRESSED, 32'(PH_CMP[ph]));
      set_idling(ph % 4);
      build_phase_stream(PHASE_BYTES, PH_BPP[ph], PH_CMP[ph]);
      send_bytes();
      phases_run++;
    end

    drain_pixels();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d bytes and %0d checked pixels over %0d register settings",
             sb.bytes_taken, sb.pixels_checked, phases_run);
    $display("sizes 0 to 7, all four formats, both modes, four idling patterns");
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tga_pkg.sv
rtl/core/tga_in_if.sv
rtl/core/tga_out_if.sv
rtl/core/tga_convert.sv
rtl/core/tga_rle_pixel_decoder.sv
bench/tb.sv
